FILE: rtl/core/floppy_controller_register_surface_assert.svh
// ----------------------------------------------------------------------------
// floppy controller register surface assertion macros
// shared concurrent assertion helpers, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef FLOPPY_CONTROLLER_REGISTER_SURFACE_ASSERT_SVH
`define FLOPPY_CONTROLLER_REGISTER_SURFACE_ASSERT_SVH

// property that holds at every edge out of reset
`define FCRS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// condition at one edge implies consequence at the next edge
`define FCRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fcrs_pkg.sv
// ----------------------------------------------------------------------------
// fcrs_pkg
// types, port and command codes for the floppy controller register surface
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcrs_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int LEN_W      = 3;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // port offsets
    localparam logic [2:0] PORT_SRA  = 3'd1;
    localparam logic [2:0] PORT_DOR  = 3'd2;
    localparam logic [2:0] PORT_TDR  = 3'd3;
    localparam logic [2:0] PORT_MSR  = 3'd4;
    localparam logic [2:0] PORT_FIFO = 3'd5;
    localparam logic [2:0] PORT_DIR  = 3'd7;

    // opcodes
    localparam logic [6:0] CMD_LOCK_LOW = 7'h14;
    localparam logic [7:0] CMD_SPECIFY  = 8'h03;
    localparam logic [7:0] CMD_SENSE    = 8'h08;
    localparam logic [7:0] CMD_VERSION  = 8'h10;
    localparam logic [7:0] CMD_PERP     = 8'h12;
    localparam logic [7:0] CMD_CONFIG   = 8'h13;
    localparam logic [7:0] CMD_PART_ID  = 8'h18;

    // result and status bytes
    localparam logic [7:0] RES_LOCKED   = 8'h10;
    localparam logic [7:0] RES_UNLOCKED = 8'h00;
    localparam logic [7:0] RES_VERSION  = 8'h90;
    localparam logic [7:0] RES_PART_ID  = 8'h41;
    localparam logic [7:0] ST0_INVALID  = 8'h80;
    localparam logic [7:0] ST0_POLL     = 8'hC0;
    localparam logic [7:0] MSR_READY    = 8'h80;
    localparam logic [7:0] MSR_BUSY     = 8'h90;
    localparam logic [7:0] MSR_RESULT   = 8'hD0;
    localparam logic [7:0] DOR_RESET    = 8'h0C;
    localparam logic [7:0] RD_OPEN      = 8'hFF;
    localparam logic [2:0] SENSE_POLLS  = 3'd4;

    typedef struct packed {
        logic       operation;
        logic [2:0] port_offset;
        logic [7:0] write_data;
    } access_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
    } result_t;

    function automatic logic [LEN_W-1:0] length_of(input logic [7:0] op);
        logic [LEN_W-1:0] len;
        len = LEN_W'(1);
        if (op == CMD_SPECIFY) len = LEN_W'(3);
        if (op == CMD_CONFIG)  len = LEN_W'(4);
        if (op == CMD_PERP)    len = LEN_W'(2);
        return len;
    endfunction

    function automatic logic [FIFO_AW:0] len_ext(input logic [LEN_W-1:0] len);
        return {{(FIFO_AW + 1 - LEN_W){1'b0}}, len};
    endfunction

    function automatic logic [FIFO_AW:0] pos_ext(input logic [FIFO_AW-1:0] pos);
        return {1'b0, pos};
    endfunction

    function automatic logic [FIFO_AW-1:0] pos_inc(input logic [FIFO_AW-1:0] pos);
        return (pos == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : pos + FIFO_AW'(1);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fcrs_core.sv
// ----------------------------------------------------------------------------
// fcrs_core
// register state, command/result fifo and per-access decode of the controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "floppy_controller_register_surface_assert.svh"

module fcrs_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire fcrs_pkg::access_t acc,
    output fcrs_pkg::result_t      res
);
    import fcrs_pkg::*;

    logic [7:0]         dor_reg, dor_next;
    logic [7:0]         tdr_reg, tdr_next;
    logic [7:0]         dsr_reg, dsr_next;
    logic [7:0]         ccr_reg, ccr_next;
    logic [7:0]         cfg_byte_reg, cfg_byte_next;
    logic [7:0]         precomp_reg, precomp_next;
    logic [2:0]         perp_reg, perp_next;
    logic               lock_reg, lock_next;
    logic [7:0]         st0_base_reg, st0_base_next;
    logic [2:0]         polls_reg, polls_next;
    logic               irq_reg, irq_next;
    logic [FIFO_AW-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               result_reg, result_next;
    logic [7:0]         opcode_reg, opcode_next;
    logic [7:0]         fifo_reg  [FIFO_DEPTH];
    logic [7:0]         fifo_next [FIFO_DEPTH];

    logic [7:0]         msr;
    logic [7:0]         rd;
    logic [7:0]         wd;
    logic [FIFO_AW-1:0] npos;
    logic               first;
    logic [LEN_W-1:0]   cmd_len;
    logic [7:0]         cmd_op;
    logic               cmd_done;
    logic               rd_last;
    logic               dor_rise;

    assign wd       = acc.write_data;
    assign npos     = pos_inc(pos_reg);
    assign first    = (pos_reg == '0);
    assign cmd_len  = first ? length_of(wd) : len_reg;
    assign cmd_op   = first ? wd : opcode_reg;
    assign cmd_done = (pos_ext(npos) == len_ext(cmd_len));
    assign rd_last  = (pos_ext(npos) == len_ext(len_reg));
    assign dor_rise = wd[2] && !dor_reg[2];
    assign msr      = result_reg ? MSR_RESULT : (first ? MSR_READY : MSR_BUSY);

    always_comb begin
        dor_next      = dor_reg;
        tdr_next      = tdr_reg;
        dsr_next      = dsr_reg;
        ccr_next      = ccr_reg;
        cfg_byte_next = cfg_byte_reg;
        precomp_next  = precomp_reg;
        perp_next     = perp_reg;
        lock_next     = lock_reg;
        st0_base_next = st0_base_reg;
        polls_next    = polls_reg;
        irq_next      = irq_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        result_next   = result_reg;
        opcode_next   = opcode_reg;
        fifo_next     = fifo_reg;
        rd            = 8'h00;

        if (acc.operation == OP_WRITE) begin
            unique case (acc.port_offset)
                PORT_DOR: begin
                    if (dor_rise) begin
                        result_next   = 1'b0;
                        len_next      = LEN_W'(1);
                        pos_next      = '0;
                        st0_base_next = ST0_POLL;
                        polls_next    = SENSE_POLLS;
                        irq_next      = 1'b1;
                    end
                    dor_next = wd;
                end
                PORT_TDR: tdr_next = wd;
                PORT_MSR: dsr_next = wd;
                PORT_DIR: ccr_next = wd;
                PORT_FIFO: begin
                    if (!result_reg) begin
                        fifo_next[pos_reg] = wd;
                        if (first) begin
                            opcode_next = wd;
                            len_next    = cmd_len;
                        end
                        if (!cmd_done) begin
                            pos_next = npos;
                        end else begin
                            pos_next = '0;
                            if (cmd_op[6:0] == CMD_LOCK_LOW) begin
                                lock_next    = cmd_op[7];
                                fifo_next[0] = cmd_op[7] ? RES_LOCKED : RES_UNLOCKED;
                                result_next  = 1'b1;
                                len_next     = LEN_W'(1);
                            end else begin
                                unique case (cmd_op)
                                    CMD_SENSE: begin
                                        if (polls_reg != 3'd0) begin
                                            fifo_next[0] = ST0_POLL |
                                                {6'b0, 2'(SENSE_POLLS - polls_reg)};
                                            polls_next   = polls_reg - 3'd1;
                                        end else if (irq_reg) begin
                                            fifo_next[0] = st0_base_reg | {6'b0, dor_reg[1:0]};
                                        end else begin
                                            fifo_next[0] = ST0_INVALID;
                                        end
                                        fifo_next[1] = 8'h00;
                                        result_next  = 1'b1;
                                        len_next     = LEN_W'(2);
                                    end
                                    CMD_VERSION: begin
                                        fifo_next[0] = RES_VERSION;
                                        result_next  = 1'b1;
                                        len_next     = LEN_W'(1);
                                    end
                                    CMD_PART_ID: begin
                                        fifo_next[0] = RES_PART_ID;
                                        result_next  = 1'b1;
                                        len_next     = LEN_W'(1);
                                    end
                                    CMD_SPECIFY: begin
                                        len_next = LEN_W'(1);
                                    end
                                    CMD_CONFIG: begin
                                        cfg_byte_next = fifo_reg[2];
                                        precomp_next  = wd;
                                        len_next      = LEN_W'(1);
                                    end
                                    CMD_PERP: begin
                                        if (wd[7]) perp_next = wd[2:0];
                                        len_next = LEN_W'(1);
                                    end
                                    default: begin
                                        fifo_next[0] = ST0_INVALID;
                                        result_next  = 1'b1;
                                        len_next     = LEN_W'(1);
                                    end
                                endcase
                            end
                        end
                    end
                end
                default: ;
            endcase
        end else begin
            unique case (acc.port_offset)
                PORT_SRA: rd = 8'h00;
                PORT_DOR: rd = dor_reg;
                PORT_TDR: rd = tdr_reg;
                PORT_MSR: rd = msr;
                PORT_FIFO: begin
                    if (result_reg) begin
                        rd = fifo_reg[pos_reg];
                        if (rd_last) begin
                            result_next = 1'b0;
                            len_next    = LEN_W'(1);
                            pos_next    = '0;
                            irq_next    = 1'b0;
                        end else begin
                            pos_next = npos;
                        end
                    end
                end
                PORT_DIR: rd = 8'h00;
                default:  rd = RD_OPEN;
            endcase
        end
    end

    assign res.read_data = rd;
    assign res.irq       = irq_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dor_reg      <= DOR_RESET;
            tdr_reg      <= 8'h00;
            dsr_reg      <= 8'h00;
            ccr_reg      <= 8'h00;
            cfg_byte_reg <= 8'h00;
            precomp_reg  <= 8'h00;
            perp_reg     <= 3'd0;
            lock_reg     <= 1'b0;
            st0_base_reg <= 8'h00;
            polls_reg    <= 3'd0;
            irq_reg      <= 1'b0;
            pos_reg      <= '0;
            len_reg      <= LEN_W'(1);
            result_reg   <= 1'b0;
            opcode_reg   <= 8'h00;
        end else if (en) begin
            dor_reg      <= dor_next;
            tdr_reg      <= tdr_next;
            dsr_reg      <= dsr_next;
            ccr_reg      <= ccr_next;
            cfg_byte_reg <= cfg_byte_next;
            precomp_reg  <= precomp_next;
            perp_reg     <= perp_next;
            lock_reg     <= lock_next;
            st0_base_reg <= st0_base_next;
            polls_reg    <= polls_next;
            irq_reg      <= irq_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            result_reg   <= result_next;
            opcode_reg   <= opcode_next;
        end
    end

    // fifo contents hold payload only
    always_ff @(posedge aclk) begin
        if (en) begin
            fifo_reg <= fifo_next;
        end
    end

    logic reset_write;
    logic reset_taken;
    logic pos_in_result;
    logic pos_in_command;

    assign reset_write    = en && (acc.operation == OP_WRITE) &&
                            (acc.port_offset == PORT_DOR) && dor_rise;
    assign reset_taken    = irq_reg && !result_reg && (pos_reg == '0) &&
                            (polls_reg == SENSE_POLLS);
    assign pos_in_result  = pos_ext(pos_reg) < len_ext(len_reg);
    assign pos_in_command = pos_ext(pos_reg) < len_ext(LEN_W'(4));

    `FCRS_ASSERT_ALWAYS(a_result_pos, !result_reg || pos_in_result, "result position past length")
    `FCRS_ASSERT_ALWAYS(a_command_pos, result_reg || pos_in_command, "command position too far")
    `FCRS_ASSERT_ALWAYS(a_polls_range, polls_reg <= SENSE_POLLS, "sense poll count out of range")
    `FCRS_ASSERT_NEXT(a_ctrl_reset, reset_write, reset_taken, "controller reset not taken")

endmodule

`default_nettype wire

FILE: rtl/core/floppy_controller_register_surface.sv
// ----------------------------------------------------------------------------
// floppy_controller_register_surface
// bus access stream in, read data and interrupt level stream out
// ----------------------------------------------------------------------------
// an accepted input beat passes the input and output registers to m_axis
// throughput: one access per cycle if m_axis is ready; one state update per access
// a stalled result holds in the output register while the input register
// still takes one more beat
// reset: synchronous active-low aresetn clears both stages and all control state
`timescale 1ns / 1ps
`default_nettype none

module floppy_controller_register_surface (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [2:0] port_offset, [10:3] write_data
    input  wire logic        s_axis_tuser,  // [0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // [7:0] read_data, [8] irq
);
    import fcrs_pkg::*;

    logic    in_valid_reg;
    access_t in_acc_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) in_valid_reg <= s_axis_tvalid;
            if (advance)       out_valid_reg <= in_valid_reg;
        end
    end

    // beat payloads
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_acc_reg.operation   <= s_axis_tuser;
            in_acc_reg.port_offset <= s_axis_tdata[2:0];
            in_acc_reg.write_data  <= s_axis_tdata[10:3];
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= core_res;
        end
    end

    fcrs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (in_valid_reg && advance),
        .acc     (in_acc_reg),
        .res     (core_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_res_reg.irq, out_res_reg.read_data};

endmodule

`default_nettype wire

FILE: sim/floppy_controller_register_surface_tb.sv
// ----------------------------------------------------------------------------
// floppy_controller_register_surface_tb
// Sends port reads and writes to the controller register surface: a short
// directed opening, then mostly complete command and result exchanges with
// random content, mixed with reset pulses and random accesses. A scoreboard
// tracks the controller state, predicts the read data and interrupt level of
// every access, and compares each result beat with that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module floppy_controller_register_surface_tb;

    import fcrs_pkg::*;

    localparam int          RANDOM_ACCESSES = 1000;
    localparam int          QUIET_TAIL      = 150;
    localparam int          HOLD_AT         = 300;
    localparam int          HOLD_CYCLES     = 200;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam int          DOR_NRESET_BIT  = 2;

    class fdc_surface_board;
        logic [7:0]         dor;
        logic [1:0]         drive_sel;
        logic [7:0]         tape_reg;
        logic [7:0]         rate_reg;
        logic [7:0]         ccr_reg;
        logic [7:0]         msr;
        logic [7:0]         cfg_byte;
        logic [7:0]         precomp;
        logic [2:0]         perp_mode;
        logic               lock_bit;
        logic [7:0]         st0_base;
        logic [2:0]         polls_left;
        logic               irq_pending;
        logic [7:0]         fifo_bytes [FIFO_DEPTH];
        logic [FIFO_AW-1:0] fifo_pos;
        logic [3:0]         cmd_len;
        logic               in_results;
        logic [7:0]         cmd_op;
        result_t            replies_due [$];
        int                 mismatches;

        function new();
            dor         = DOR_RESET;
            drive_sel   = '0;
            tape_reg    = '0;
            rate_reg    = '0;
            ccr_reg     = '0;
            msr         = MSR_READY;
            cfg_byte    = '0;
            precomp     = '0;
            perp_mode   = '0;
            lock_bit    = 1'b0;
            st0_base    = '0;
            polls_left  = '0;
            irq_pending = 1'b0;
            foreach (fifo_bytes[i]) fifo_bytes[i] = '0;
            fifo_pos    = '0;
            cmd_len     = 4'd1;
            in_results  = 1'b0;
            cmd_op      = '0;
            mismatches  = 0;
        endfunction

        function void enter_command_phase();
            in_results = 1'b0;
            cmd_len    = 4'd1;
            fifo_pos   = '0;
            msr        = MSR_READY;
        endfunction

        function void enter_result_phase(input logic [3:0] len);
            in_results = 1'b1;
            cmd_len    = len;
            fifo_pos   = '0;
            msr        = MSR_RESULT;
        endfunction

        function logic [FIFO_AW-1:0] step_pos(input logic [FIFO_AW-1:0] p);
            return FIFO_AW'((int'(p) + 1) % FIFO_DEPTH);
        endfunction

        function void note_access(input access_t a);
            result_t            r;
            logic [7:0]         v;
            logic [FIFO_AW-1:0] nxt;
            v = a.write_data;
            r.read_data = 8'h00;
            if (a.operation == OP_WRITE) begin
                case (a.port_offset)
                    PORT_DOR: begin
                        // rising reset bit restarts the controller
                        if (v[DOR_NRESET_BIT] && !dor[DOR_NRESET_BIT]) begin
                            enter_command_phase();
                            st0_base    = ST0_POLL;
                            polls_left  = SENSE_POLLS;
                            irq_pending = 1'b1;
                        end
                        dor       = v;
                        drive_sel = v[1:0];
                    end
                    PORT_TDR: tape_reg = v;
                    PORT_MSR: rate_reg = v;
                    PORT_DIR: ccr_reg  = v;
                    PORT_FIFO: if (!in_results) begin
                        if (fifo_pos == '0) begin
                            cmd_op = v;
                            if (v[6:0] == CMD_LOCK_LOW) begin
                                cmd_len = 4'd1;
                            end else begin
                                case (v)
                                    CMD_SPECIFY: cmd_len = 4'd3;
                                    CMD_CONFIG:  cmd_len = 4'd4;
                                    CMD_PERP:    cmd_len = 4'd2;
                                    default:     cmd_len = 4'd1;
                                endcase
                            end
                        end
                        fifo_bytes[fifo_pos] = v;
                        nxt = step_pos(fifo_pos);
                        if (nxt == cmd_len) begin
                            // last command byte in, execute
                            if (cmd_op[6:0] == CMD_LOCK_LOW) begin
                                lock_bit      = cmd_op[7];
                                fifo_bytes[0] = cmd_op[7] ? RES_LOCKED : RES_UNLOCKED;
                                enter_result_phase(4'd1);
                            end else begin
                                case (cmd_op)
                                    CMD_SENSE: begin
                                        if (polls_left != '0) begin
                                            fifo_bytes[0] = ST0_POLL |
                                                {6'b0, 2'(SENSE_POLLS - polls_left)};
                                            polls_left = polls_left - 3'd1;
                                        end else if (irq_pending) begin
                                            fifo_bytes[0] = st0_base | {6'b0, drive_sel};
                                        end else begin
                                            fifo_bytes[0] = ST0_INVALID;
                                        end
                                        fifo_bytes[1] = 8'h00;
                                        enter_result_phase(4'd2);
                                    end
                                    CMD_VERSION: begin
                                        fifo_bytes[0] = RES_VERSION;
                                        enter_result_phase(4'd1);
                                    end
                                    CMD_PART_ID: begin
                                        fifo_bytes[0] = RES_PART_ID;
                                        enter_result_phase(4'd1);
                                    end
                                    CMD_SPECIFY: enter_command_phase();
                                    CMD_CONFIG: begin
                                        cfg_byte = fifo_bytes[2];
                                        precomp  = v;
                                        enter_command_phase();
                                    end
                                    CMD_PERP: begin
                                        if (v[7]) perp_mode = v[2:0];
                                        enter_command_phase();
                                    end
                                    default: begin
                                        fifo_bytes[0] = ST0_INVALID;
                                        enter_result_phase(4'd1);
                                    end
                                endcase
                            end
                        end else begin
                            fifo_pos = nxt;
                            msr      = MSR_BUSY;
                        end
                    end
                    default: ;
                endcase
            end else begin
                case (a.port_offset)
                    PORT_SRA, PORT_DIR: r.read_data = 8'h00;
                    PORT_DOR: r.read_data = dor | {6'b0, drive_sel};
                    PORT_TDR: r.read_data = tape_reg;
                    PORT_MSR: r.read_data = msr;
                    PORT_FIFO: if (in_results) begin
                        r.read_data = fifo_bytes[fifo_pos];
                        nxt = step_pos(fifo_pos);
                        if (nxt == cmd_len) begin
                            enter_command_phase();
                            irq_pending = 1'b0;
                        end else begin
                            fifo_pos = nxt;
                        end
                    end
                    default: r.read_data = RD_OPEN;
                endcase
            end
            r.irq = irq_pending;
            replies_due.push_back(r);
        endfunction

        function void check_reply(input logic [7:0] read_data, input logic irq);
            result_t want;
            if (replies_due.size() == 0) begin
                $error("result beat with no access waiting: read_data %02h irq %0b",
                       read_data, irq);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (read_data !== want.read_data) begin
                $error("read_data mismatch: expected %02h, actual %02h",
                       want.read_data, read_data);
                mismatches++;
            end
            if (irq !== want.irq) begin
                $error("irq mismatch: expected %0b, actual %0b", want.irq, irq);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [2:0] port_offset, [10:3] write_data
    logic        s_axis_tuser;   // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] read_data, [8] irq

    fdc_surface_board board;
    int unsigned      accesses_sent = 0;
    int unsigned      cycles_run    = 0;
    bit               source_gaps   = 1'b0;
    bit               sink_stalls   = 1'b0;
    bit               long_hold_req = 1'b0;

    floppy_controller_register_surface i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result beats
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            board.check_reply(m_axis_tdata[7:0], m_axis_tdata[8]);
        end
    end

    // receiver: random stall bursts and one long hold-off
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (aresetn && sink_stalls && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= aresetn;
            end
        end
    end

    task automatic bus_access(input logic op, input logic [2:0] offset, input logic [7:0] data);
        access_t a;
        a.operation   = op;
        a.port_offset = offset;
        a.write_data  = data;
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, data, offset};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_access(a);
        accesses_sent++;
    endtask

    // opcode, its parameter bytes, then the result bytes until the command phase, unless it stops early at random
    task automatic issue_command(input logic [7:0] op);
        bus_access(OP_WRITE, PORT_FIFO, op);
        while (board.msr == MSR_BUSY) begin
            if ($urandom_range(0, 19) == 0) return;
            if ($urandom_range(0, 4) == 0) bus_access(OP_READ, PORT_MSR, 8'($urandom));
            bus_access(OP_WRITE, PORT_FIFO, 8'($urandom));
        end
        while (board.in_results) begin
            if ($urandom_range(0, 19) == 0) return;
            if ($urandom_range(0, 3) == 0) bus_access(OP_READ, PORT_MSR, 8'($urandom));
            bus_access(OP_READ, PORT_FIFO, 8'($urandom));
        end
    endtask

    initial begin
        logic [7:0]  op;
        logic [7:0]  data;
        int unsigned first_random;
        int unsigned mode_mark;
        int unsigned pick;
        bit          held;

        board = new();
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all ports written with ones; the fifo byte is an invalid opcode
        for (int off = 0; off < 8; off++) bus_access(OP_WRITE, 3'(off), 8'hFF);
        // command byte during the result phase is dropped
        bus_access(OP_WRITE, PORT_FIFO, CMD_VERSION);
        for (int off = 0; off < 8; off++) bus_access(OP_READ, 3'(off), 8'h00);
        // fifo read in the command phase
        bus_access(OP_READ, PORT_FIFO, 8'hFF);
        // controller reset, then the first drive poll
        bus_access(OP_WRITE, PORT_DOR, 8'h00);
        bus_access(OP_WRITE, PORT_DOR, 8'(1 << DOR_NRESET_BIT));
        issue_command(CMD_SENSE);
        issue_command({1'b1, CMD_LOCK_LOW});

        first_random = accesses_sent;
        mode_mark    = accesses_sent;
        held         = 1'b0;
        while (accesses_sent < first_random + RANDOM_ACCESSES) begin
            if (accesses_sent + QUIET_TAIL >= first_random + RANDOM_ACCESSES) begin
                source_gaps = 1'b0;
                sink_stalls = 1'b0;
            end else if (accesses_sent >= mode_mark) begin
                mode_mark   = mode_mark + 100;
                source_gaps = ($urandom_range(0, 2) != 0);
                sink_stalls = ($urandom_range(0, 2) != 0);
            end
            if (!held && accesses_sent >= first_random + HOLD_AT) begin
                long_hold_req = 1'b1;
                held          = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 8))
                    0:       op = CMD_SENSE;
                    1:       op = CMD_VERSION;
                    2:       op = CMD_PART_ID;
                    3:       op = {1'b0, CMD_LOCK_LOW};
                    4:       op = {1'b1, CMD_LOCK_LOW};
                    5:       op = CMD_SPECIFY;
                    6:       op = CMD_CONFIG;
                    7:       op = CMD_PERP;
                    default: op = 8'($urandom);
                endcase
                issue_command(op);
            end else if (pick < 85) begin
                // reset bit low, then random value, rising edge half the time
                data = 8'($urandom);
                data[DOR_NRESET_BIT] = 1'b0;
                bus_access(OP_WRITE, PORT_DOR, data);
                bus_access(OP_WRITE, PORT_DOR, 8'($urandom));
            end else begin
                bus_access(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                           8'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (board.replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
